// ----- rtl/core/stt_pkg.sv -----
// Shared types, sizes and codes for the sorted tick table.
package stt_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int TICK_W = 31;
    localparam int KIND_W = 3;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RM_IDX = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RM_KEY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [KIND_W-1:0] kind;
    } t_entry;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  result_index;
        logic [CNT_W-1:0]  entry_count;
        logic [TICK_W-1:0] entry_tick;
        logic [KIND_W-1:0] entry_kind;
        logic              entry_sync;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_FND_RD,
        S_FND_CHK,
        S_RM_RD,
        S_RM_WR,
        S_RDC_CHK,
        S_RDL_RD,
        S_RDL_CHK,
        S_RDR_RD,
        S_RDR_CHK,
        S_RESP
    } t_state;

endpackage

// ----- rtl/core/stt_if.sv -----
// Command and response channel interfaces of the sorted tick table.
interface stt_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [stt_pkg::MODE_W-1:0] mode;
    logic [stt_pkg::TICK_W-1:0] tick;
    logic [stt_pkg::KIND_W-1:0] kind;
    logic [stt_pkg::IDX_W-1:0]  position;

    modport source (output valid, mode, tick, kind, position, input ready);
    modport sink   (input valid, mode, tick, kind, position, output ready);
endinterface

interface stt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [stt_pkg::STAT_W-1:0] status;
    logic [stt_pkg::IDX_W-1:0]  result_index;
    logic [stt_pkg::CNT_W-1:0]  entry_count;
    logic [stt_pkg::TICK_W-1:0] entry_tick;
    logic [stt_pkg::KIND_W-1:0] entry_kind;
    logic                       entry_sync;

    modport source (output valid, status, result_index, entry_count, entry_tick,
                    entry_kind, entry_sync, input ready);
    modport sink   (input valid, status, result_index, entry_count, entry_tick,
                    entry_kind, entry_sync, output ready);
endinterface

// ----- rtl/core/stt_entry_ram.sv -----
// Single-port-write, single-port-read entry memory with registered read data.
module stt_entry_ram #(
    parameter int WIDTH  = 34,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sorted_tick_table_core.sv -----
// Sorted tick table: command sequencer over one entry memory, result register.
//
// i_cmd carries one command word (mode, tick, kind, position); o_rsp returns
// exactly one response word per command, in order. The table holds up to
// DEPTH entries sorted by ascending tick in a single memory with registered
// read data. The sequencer steps through the table one entry at a time,
// reading an entry and, for insert and remove, writing it one slot over:
//   insert         shifts entries at or above the slot up, top entry first
//   find           scans up from index 0 to a match, full scan on a miss
//   remove by key  find, then shifts entries above the match down
//   remove at idx  shifts entries above the index down
//   read           reads the entry and its neighbors for the sync mark
// Refused, out-of-range and unknown commands respond without touching the memory. The worst
// case is a full scan or a shift across the whole table.
// One command is worked on at a time; i_cmd.ready is high only while idle.
// The response sits in an output register, so the next command is taken while
// a response still waits; a stalled receiver holds the sequencer only when a
// second response is ready to leave. Reset empties the table (count zero);
// no clearing pass is needed.
module sorted_tick_table_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_cmd_if.sink    i_cmd,
    stt_rsp_if.source  o_rsp
);

    import stt_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [IDX_W-1:0]   r_pos, n_pos;
    t_result            r_res, n_res;
    t_result            r_out;
    logic               r_out_valid;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_entry             w_wdata;
    logic               w_re;
    logic [IDX_W-1:0]   w_raddr;
    t_entry             w_rdata;
    logic               w_load;
    logic [CNT_W-1:0]   w_pos_ext;

    stt_entry_ram #(
        .WIDTH  ($bits(t_entry)),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_load    = (r_state == S_RESP) && (!r_out_valid || o_rsp.ready);
    assign w_pos_ext = {1'b0, r_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_mode <= n_mode;
        r_tick <= n_tick;
        r_kind <= n_kind;
        r_pos  <= n_pos;
        r_res  <= n_res;
        if (w_load) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_mode      = r_mode;
        n_tick      = r_tick;
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_res       = r_res;
        w_we        = 1'b0;
        w_waddr     = r_idx[IDX_W-1:0];
        w_wdata     = '{tick: r_tick, kind: r_kind};
        w_re        = 1'b0;
        w_raddr     = r_idx[IDX_W-1:0];
        i_cmd.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_mode = i_cmd.mode;
                    n_tick = i_cmd.tick;
                    n_kind = i_cmd.kind;
                    n_pos  = i_cmd.position;
                    n_res  = '0;
                    unique case (i_cmd.mode)
                        MODE_INSERT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_res.status = STAT_FULL;
                                n_state      = S_RESP;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        MODE_RM_IDX: begin
                            if ({1'b0, i_cmd.position} >= r_count) begin
                                n_res.status = STAT_MISS;
                                n_state      = S_RESP;
                            end else begin
                                n_idx   = {1'b0, i_cmd.position};
                                n_state = S_RM_RD;
                            end
                        end
                        MODE_RM_KEY, MODE_FIND: begin
                            n_idx   = '0;
                            n_state = S_FND_RD;
                        end
                        MODE_READ: begin
                            if ({1'b0, i_cmd.position} >= r_count) begin
                                n_res.status = STAT_MISS;
                                n_state      = S_RESP;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = i_cmd.position;
                                n_state = S_RDC_CHK;
                            end
                        end
                        default: begin
                            n_res.status = STAT_MISS;
                            n_state      = S_RESP;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_idx == '0) begin
                    w_we               = 1'b1;
                    w_waddr            = '0;
                    n_res.result_index = '0;
                    n_count            = r_count + CNT_W'(1);
                    n_state            = S_RESP;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = IDX_W'(r_idx - CNT_W'(1));
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                w_we = 1'b1;
                if (w_rdata.tick >= r_tick) begin
                    w_wdata = w_rdata;
                    n_idx   = r_idx - CNT_W'(1);
                    n_state = S_INS_RD;
                end else begin
                    n_res.result_index = r_idx[IDX_W-1:0];
                    n_count            = r_count + CNT_W'(1);
                    n_state            = S_RESP;
                end
            end
            S_FND_RD: begin
                if (r_idx == r_count) begin
                    n_res.status = STAT_MISS;
                    n_state      = S_RESP;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_FND_CHK;
                end
            end
            S_FND_CHK: begin
                if (w_rdata.tick == r_tick && w_rdata.kind == r_kind) begin
                    n_res.result_index = r_idx[IDX_W-1:0];
                    n_state = (r_mode == MODE_RM_KEY) ? S_RM_RD : S_RESP;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_FND_RD;
                end
            end
            S_RM_RD: begin
                if (r_idx + CNT_W'(1) >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = IDX_W'(r_idx + CNT_W'(1));
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_idx   = r_idx + CNT_W'(1);
                n_state = S_RM_RD;
            end
            S_RDC_CHK: begin
                n_res.entry_tick = w_rdata.tick;
                n_res.entry_kind = w_rdata.kind;
                n_state = (r_pos != '0) ? S_RDL_RD : S_RDR_RD;
            end
            S_RDL_RD: begin
                w_re    = 1'b1;
                w_raddr = r_pos - IDX_W'(1);
                n_state = S_RDL_CHK;
            end
            S_RDL_CHK: begin
                if (w_rdata.tick == r_res.entry_tick) begin
                    n_res.entry_sync = 1'b1;
                end
                n_state = S_RDR_RD;
            end
            S_RDR_RD: begin
                if (w_pos_ext + CNT_W'(1) < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = r_pos + IDX_W'(1);
                    n_state = S_RDR_CHK;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RDR_CHK: begin
                if (w_rdata.tick == r_res.entry_tick) begin
                    n_res.entry_sync = 1'b1;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // response word always carries the count after the command
        n_res.entry_count = n_count;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.result_index = r_out.result_index;
    assign o_rsp.entry_count  = r_out.entry_count;
    assign o_rsp.entry_tick   = r_out.entry_tick;
    assign o_rsp.entry_kind   = r_out.entry_kind;
    assign o_rsp.entry_sync   = r_out.entry_sync;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_count_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> r_state == S_RESP)
        else $error("entry count changed outside command completion");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_we)
        else $error("table written while idle");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == STAT_FULL) |-> o_rsp.entry_count == CNT_W'(DEPTH))
        else $error("full status with room in table");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != STAT_DONE) |->
            (o_rsp.entry_tick == '0 && o_rsp.entry_kind == '0 && !o_rsp.entry_sync))
        else $error("failed command returned entry data");

endmodule
